/* rtl/core/sqmr_pkg.sv */
// ----------------------------------------------------------------------------
// sqmr_pkg
// Shared types and constants of the split quota message ring controller.
// ----------------------------------------------------------------------------
package sqmr_pkg;

  localparam int RING_SLOTS = 64;
  localparam int GEN_BITS   = 16;
  localparam int HALF_RING  = RING_SLOTS / 2;

  localparam int PTR_W  = $clog2(RING_SLOTS);
  localparam int SIZE_W = PTR_W + 1;
  localparam int CAP_W  = 6;
  localparam int CNT_W  = 6;
  localparam int ACT_W  = 3;
  localparam int PGEN_W = 16;
  localparam int CIDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_RX_INIT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_RX_GET  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CONSUME = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TX_INIT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TX_GET  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PRODUCE = 3'd5;

  localparam logic [CIDX_W-1:0] CFG_RX_CAP = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_TX_CAP = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd8;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic              subscribe;
    logic [PGEN_W-1:0] partner_generation;
  } in_item_t;

  typedef struct packed {
    logic             slot_found;
    logic [CNT_W-1:0] slot_index;
    logic [CNT_W-1:0] receive_count;
    logic [CNT_W-1:0] send_count;
    logic             wake_receiver;
    logic             wake_sender;
    logic             fault;
  } out_item_t;

  typedef struct packed {
    logic [PTR_W-1:0]    read_start;
    logic [PTR_W-1:0]    side_border;
    logic [PTR_W-1:0]    send_end;
    logic                receiver_waiting;
    logic                sender_waiting;
    logic [GEN_BITS-1:0] known_sender_gen;
    logic [GEN_BITS-1:0] known_receiver_gen;
  } ring_state_t;

endpackage

/* rtl/core/sqmr_in_stage.sv */
// ----------------------------------------------------------------------------
// sqmr_in_stage
// Input register: captures one transaction per cycle with its valid flag.
// ----------------------------------------------------------------------------
module sqmr_in_stage import sqmr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     take,
  input  in_item_t item,
  output logic     item_valid,
  output in_item_t item_q
);

  logic     valid_r;
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item;
    end
  end

  assign item_valid = valid_r;
  assign item_q     = item_r;

endmodule

/* rtl/core/sqmr_action.sv */
// ----------------------------------------------------------------------------
// sqmr_action
// Action decode: next ring pointers, flags and the result of one transaction.
// ----------------------------------------------------------------------------
module sqmr_action import sqmr_pkg::*; (
  input  in_item_t         item,
  input  ring_state_t      state,
  input  logic [CAP_W-1:0] rx_cap,
  input  logic [CAP_W-1:0] tx_cap,
  output ring_state_t      state_nxt,
  output out_item_t        result
);

  function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CAP_W'(1);
    end else if (c > CAP_W'(HALF_RING)) begin
      r = CAP_W'(HALF_RING);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p,
                                                input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] s;
    s = {1'b0, p} + SIZE_W'(1);
    if (s >= sz) begin
      s = '0;
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] ring_dist(input logic [PTR_W-1:0] e,
                                                  input logic [PTR_W-1:0] s,
                                                  input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] d;
    if (e >= s) begin
      d = {1'b0, e} - {1'b0, s};
    end else begin
      d = {1'b0, e} + sz - {1'b0, s};
    end
    return d;
  endfunction

  logic [CAP_W-1:0]    rx_eff;
  logic [CAP_W-1:0]    tx_eff;
  logic [SIZE_W-1:0]   size;
  logic [SIZE_W-1:0]   rx_dist;
  logic [SIZE_W-1:0]   tx_dist;
  logic [GEN_BITS-1:0] gen;
  logic [PTR_W-1:0]    send_end_inc;
  logic                found;
  logic [PTR_W-1:0]    slot;
  logic                wake_r;
  logic                wake_s;
  logic                flt;

  assign rx_eff       = eff_cap(rx_cap);
  assign tx_eff       = eff_cap(tx_cap);
  assign size         = SIZE_W'(rx_eff) + SIZE_W'(tx_eff);
  assign rx_dist      = ring_dist(state.side_border, state.read_start, size);
  assign tx_dist      = ring_dist(state.send_end, state.side_border, size);
  assign gen          = item.partner_generation[GEN_BITS-1:0];
  assign send_end_inc = ring_inc(state.send_end, size);

  always_comb begin
    state_nxt = state;
    found     = 1'b0;
    slot      = '0;
    wake_r    = 1'b0;
    wake_s    = 1'b0;
    flt       = 1'b0;
    case (item.action)
      ACT_RX_INIT: begin
        state_nxt.read_start         = state.side_border;
        state_nxt.receiver_waiting   = 1'b0;
        state_nxt.known_receiver_gen = gen;
      end
      ACT_RX_GET: begin
        if (state.side_border != state.read_start) begin
          found = 1'b1;
          slot  = state.read_start;
        end else if (item.subscribe) begin
          state_nxt.receiver_waiting = 1'b1;
        end
      end
      ACT_CONSUME: begin
        if (state.read_start == state.side_border) begin
          flt = 1'b1;
        end else begin
          state_nxt.read_start = ring_inc(state.read_start, size);
          if (gen == state.known_sender_gen && state.side_border != state.send_end) begin
            state_nxt.side_border = ring_inc(state.side_border, size);
            if (state.sender_waiting) begin
              state_nxt.sender_waiting = 1'b0;
              wake_s                   = 1'b1;
            end
          end
        end
      end
      ACT_TX_INIT: begin
        state_nxt.send_end         = state.side_border;
        state_nxt.sender_waiting   = 1'b0;
        state_nxt.known_sender_gen = gen;
      end
      ACT_TX_GET: begin
        if (tx_dist < SIZE_W'(tx_eff)) begin
          found = 1'b1;
          slot  = state.send_end;
        end else if (item.subscribe) begin
          state_nxt.sender_waiting = 1'b1;
        end
      end
      ACT_PRODUCE: begin
        if (tx_dist >= SIZE_W'(tx_eff)) begin
          flt = 1'b1;
        end else begin
          state_nxt.send_end = send_end_inc;
          if (gen == state.known_receiver_gen) begin
            if (rx_dist < SIZE_W'(rx_eff)) begin
              state_nxt.side_border = send_end_inc;
              if (state.receiver_waiting) begin
                state_nxt.receiver_waiting = 1'b0;
                wake_r                     = 1'b1;
              end
            end
          end else begin
            state_nxt.side_border = send_end_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.slot_found    = found;
    result.slot_index    = CNT_W'(slot);
    result.receive_count =
      CNT_W'(ring_dist(state_nxt.side_border, state_nxt.read_start, size));
    result.send_count    =
      CNT_W'(ring_dist(state_nxt.send_end, state_nxt.side_border, size));
    result.wake_receiver = wake_r;
    result.wake_sender   = wake_s;
    result.fault         = flt;
  end

endmodule

/* rtl/core/split_quota_message_ring_controller.sv */
// ----------------------------------------------------------------------------
// split_quota_message_ring_controller
// Slot pointer controller of a one-sender, one-receiver message ring.
// ----------------------------------------------------------------------------
// Path: an accepted transaction is held in the input register, decoded, and
// its result and out_valid are registered in the output register.
// Throughput: one transaction per cycle; busy is tied low, and a single
// decode stage lies between the input register and the result register.
// Reset (synchronous, rst_n low): pointers, waiting flags and generations
// clear, both capacities return to 8. A capacity write clears the ring too.
// ----------------------------------------------------------------------------
module split_quota_message_ring_controller import sqmr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CAP_W-1:0]  cfg_data
);

  logic             take;
  logic             item_valid;
  in_item_t         item_q;
  ring_state_t      state_r;
  ring_state_t      state_nxt;
  out_item_t        result;
  logic [CAP_W-1:0] rx_cap_r;
  logic [CAP_W-1:0] tx_cap_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  assign busy = 1'b0;
  assign take = start && !busy;

  sqmr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (in_data),
    .item_valid (item_valid),
    .item_q     (item_q)
  );

  sqmr_action u_action (
    .item      (item_q),
    .state     (state_r),
    .rx_cap    (rx_cap_r),
    .tx_cap    (tx_cap_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_cap_r <= CAP_RESET;
      tx_cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RX_CAP) begin
        rx_cap_r <= cfg_data;
      end
      if (cfg_index == CFG_TX_CAP) begin
        tx_cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= '0;
    end else if (item_valid) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/sqmr_checker.sv */
// ----------------------------------------------------------------------------
// sqmr_checker
// Port-level checks of the ring controller, bound to the top level.
// ----------------------------------------------------------------------------
module sqmr_checker import sqmr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted transaction");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |->
      !out_data.slot_found && !out_data.wake_receiver && !out_data.wake_sender)
    else $error("faulted transaction carries other flags");

  a_single_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.wake_receiver |-> !out_data.wake_sender && !out_data.slot_found)
    else $error("receiver wake combined with other flags");

endmodule

bind split_quota_message_ring_controller sqmr_checker u_sqmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
